// File: rtl/lifo_stack_with_search_macros.svh
// assertion macros used by the port-level checker
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication, checked out of reset
`define LSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lss check failed");

// next-cycle implication, checked out of reset
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lss check failed");

`endif

// File: rtl/lss_pkg.sv
// shared types and constants of the lifo stack with search
`timescale 1ns / 1ps
`default_nettype none
package lss_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int WORD_W = 32;
    localparam int OUT_W  = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic                     found;
        logic [OUT_W-1:0]         position;
        logic signed [WORD_W-1:0] top_value;
        logic                     is_empty;
        logic [OUT_W-1:0]         entry_count;
    } res_t;

endpackage
`default_nettype wire

// File: rtl/lss_front.sv
// front end: takes request beats, decodes them and queues commands
`timescale 1ns / 1ps
`default_nettype none
module lss_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [1:0]                       req_type,
    input  wire logic signed [lss_pkg::WORD_W-1:0] value,
    output logic                                  cmd_valid,
    input  wire logic                             cmd_pop,
    output lss_pkg::cmd_t                         cmd
);
    import lss_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       in_acc;
    logic       out_acc;
    cmd_t       in_cmd;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign in_acc    = push && !full;
    assign out_acc   = cmd_pop && cmd_valid;

    always_comb
    begin
        in_cmd.op    = op_t'(req_type);
        in_cmd.value = value;
        wr_ptr_next  = in_acc ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next  = out_acc ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next     = cnt_reg;
        if (in_acc && !out_acc)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lss_back.sv
// back end: stack memory, request sequencer and result queue
`timescale 1ns / 1ps
`default_nettype none
module lss_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    input  wire lss_pkg::cmd_t cmd,
    output logic               res_empty,
    input  wire logic          res_pop,
    output lss_pkg::res_t      res
);
    import lss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_SRCH = 3'b100
    } state_t;

    // stack storage, one write and one registered read port
    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [WORD_W-1:0] top_reg, top_next;
    logic signed [WORD_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]         scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]         scan_left_reg, scan_left_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;

    res_t                     rq_reg [2];
    logic                     rq_wr_reg, rq_rd_reg;
    logic [1:0]               rq_cnt_reg, rq_cnt_next;

    logic                     start;
    logic                     emit;
    logic                     rq_out;
    status_t                  r_status;
    logic                     r_found;
    logic [CNT_W-1:0]         r_pos;
    res_t                     new_res;

    assign start     = (state_reg == S_IDLE) && cmd_valid && (rq_cnt_reg != 2'd2);
    assign cmd_pop   = start;
    assign res_empty = (rq_cnt_reg == 2'd0);
    assign res       = rq_reg[rq_rd_reg];
    assign rq_out    = res_pop && !res_empty;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        key_next       = key_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        pos_next       = pos_reg;
        emit           = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = IDX_W'(cnt_reg);
        r_status       = ST_OK;
        r_found        = 1'b0;
        r_pos          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            emit = 1'b1;
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                r_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                top_next = cmd.value;
                                cnt_next = CNT_W'(cnt_reg + 1'b1);
                            end
                        end
                        OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                r_status = ST_EMPTY;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                cnt_next = CNT_W'(cnt_reg - 1'b1);
                                if (cnt_reg == CNT_W'(1))
                                begin
                                    emit = 1'b1;
                                end
                                else
                                begin
                                    // fetch the entry that becomes the new top
                                    rd_en      = 1'b1;
                                    rd_addr    = IDX_W'(cnt_reg - CNT_W'(2));
                                    state_next = S_LOAD;
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                r_status = ST_EMPTY;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = IDX_W'(cnt_reg - 1'b1);
                                key_next       = cmd.value;
                                scan_addr_next = IDX_W'(cnt_reg - CNT_W'(2));
                                scan_left_next = CNT_W'(cnt_reg - 1'b1);
                                pos_next       = CNT_W'(1);
                                state_next     = S_SRCH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                            emit     = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                top_next   = rd_data_reg;
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_SRCH:
            begin
                // rd_data_reg holds the entry at place pos_reg from the top
                if (rd_data_reg == key_reg)
                begin
                    r_found    = 1'b1;
                    r_pos      = pos_reg;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else if (scan_left_reg == '0)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg;
                    scan_addr_next = scan_addr_reg - 1'b1;
                    scan_left_next = CNT_W'(scan_left_reg - 1'b1);
                    pos_next       = CNT_W'(pos_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        new_res.status      = r_status;
        new_res.found       = r_found;
        new_res.position    = OUT_W'(r_pos);
        new_res.top_value   = (cnt_next == '0) ? '0 : top_next;
        new_res.is_empty    = (cnt_next == '0);
        new_res.entry_count = OUT_W'(cnt_next);

        rq_cnt_next = rq_cnt_reg;
        if (emit && !rq_out)
        begin
            rq_cnt_next = rq_cnt_reg + 2'd1;
        end
        else if (!emit && rq_out)
        begin
            rq_cnt_next = rq_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rq_wr_reg  <= emit ? ~rq_wr_reg : rq_wr_reg;
            rq_rd_reg  <= rq_out ? ~rq_rd_reg : rq_rd_reg;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        key_reg       <= key_next;
        scan_addr_reg <= scan_addr_next;
        scan_left_reg <= scan_left_next;
        pos_reg       <= pos_next;
        if (emit)
        begin
            rq_reg[rq_wr_reg] <= new_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/lifo_stack_with_search.sv
// Bounded stack of 16 signed 32-bit words with push, pop, search and clear
// requests, one result beat per request beat, in request order. A two-entry
// command queue takes request beats while the sequencer works, and a
// two-entry result queue holds results until they are popped. The sequencer
// runs one request at a time. Push, clear, pop or search on an empty stack,
// and a pop that empties the stack finish in the idle state; other pops go
// through the load state, since the new top is read back from the stack
// memory. A search compares entries from the top down until the first match
// or until every entry is compared; the single read port of the stack
// memory, one entry per cycle, sets the search time. An accepted request beat
// is registered in the command queue and its result then in the result queue.
`timescale 1ns / 1ps
`default_nettype none
module lifo_stack_with_search (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [1:0]                        req_type,
    input  wire logic signed [lss_pkg::WORD_W-1:0] value,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [1:0]                             status,
    output logic                                   found,
    output logic [lss_pkg::OUT_W-1:0]              position,
    output logic signed [lss_pkg::WORD_W-1:0]      top_value,
    output logic                                   is_empty,
    output logic [lss_pkg::OUT_W-1:0]              entry_count
);
    import lss_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res;

    lss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    lss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_empty (empty),
        .res_pop   (pop),
        .res       (res)
    );

    assign status      = res.status;
    assign found       = res.found;
    assign position    = res.position;
    assign top_value   = res.top_value;
    assign is_empty    = res.is_empty;
    assign entry_count = res.entry_count;

endmodule
`default_nettype wire

// File: rtl/lss_checker.sv
// port-level checks on the stack, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_stack_with_search_macros.svh"
module lss_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              empty,
    input  wire logic                              pop,
    input  wire logic [1:0]                        status,
    input  wire logic                              found,
    input  wire logic [lss_pkg::OUT_W-1:0]         position,
    input  wire logic signed [lss_pkg::WORD_W-1:0] top_value,
    input  wire logic                              is_empty,
    input  wire logic [lss_pkg::OUT_W-1:0]         entry_count
);
    import lss_pkg::*;

    // a full report only comes with a full stack
    `LSS_ASSERT_NOW(a_full_count, clk, rst_n, !empty && status == ST_FULL, entry_count == OUT_W'(DEPTH) && !found)
    // an empty stack shows a zero top word
    `LSS_ASSERT_NOW(a_empty_top, clk, rst_n, !empty && is_empty, top_value == '0 && entry_count == '0)
    // a match always carries a place and an ok status
    `LSS_ASSERT_NOW(a_found_pos, clk, rst_n, !empty && found, position != '0 && status == ST_OK)
    // a waiting result beat stays put until popped
    `LSS_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(top_value) && $stable(entry_count))

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);
`default_nettype wire
